FILE: rtl/rotate_point_about_center_assert.svh
// Assertion macros for the point rotation block.
// No dependencies; included by the files that check their own logic.
`ifndef ROTATE_POINT_ABOUT_CENTER_ASSERT_SVH
`define ROTATE_POINT_ABOUT_CENTER_ASSERT_SVH

// check in the same cycle
`define RPAC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: %m");

// check in the next cycle
`define RPAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: %m");

`endif

FILE: rtl/rpac_pkg.sv
// Types, constants and tables for the point rotation block.
// No dependencies; used by the CORDIC stage and the top level.
`timescale 1ns / 1ps
`default_nettype none

package rpac_pkg;

  localparam int unsigned CORDIC_STAGES_DEF = 20;

  localparam int unsigned DATA_W    = 54;
  localparam int unsigned ANG_W     = 34;
  localparam int unsigned FRAC_BITS = 16;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [ANG_W-1:0]  ang_t;

  typedef struct packed {
    data_t x;
    data_t y;
    ang_t  z;
  } cordic_word_t;

  localparam logic [31:0] GAIN_INV      = 32'h9B74EDA8;
  localparam logic [31:0] SNAP_TOL      = 32'd683565;
  localparam logic [31:0] QUARTER       = 32'h40000000;
  localparam logic [31:0] HALF          = 32'h80000000;
  localparam logic [31:0] THREE_QUARTER = 32'hC0000000;
  localparam logic [63:0] ROUND_Q32     = 64'h0000_0000_8000_0000;
  localparam data_t       ROUND_FRAC    = data_t'(1) <<< (FRAC_BITS - 1);

  localparam ang_t QUARTER_Z = {{(ANG_W-32){1'b0}}, QUARTER};
  localparam ang_t HALF_Z    = {{(ANG_W-32){1'b0}}, HALF};

  localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  // turn in 1/128 degree to binary angle: t = 90*a + b
  localparam logic [15:0]  FULL_TURN    = 16'd46080;
  localparam int unsigned  TURN_DIV_N   = 90;
  localparam logic [15:0]  TURN_DIV     = 16'(TURN_DIV_N);
  localparam int unsigned  RECIP_SHIFT  = 24;
  localparam logic [17:0]  TURN_RECIP   =
    18'(((64'd1 << RECIP_SHIFT) + 64'(TURN_DIV_N) - 64'd1) / TURN_DIV_N);
  localparam int unsigned  TURN_A_W     = 9;
  localparam int unsigned  TURN_A_SHIFT = 23;
  localparam int unsigned  TURN_B_W     = 7;

  typedef logic [TURN_A_SHIFT-1:0] frac_tab_t [TURN_DIV_N];

  function automatic frac_tab_t build_frac_tab();
    frac_tab_t tab;
    for (int b = 0; b < TURN_DIV_N; b++) begin
      tab[b] = TURN_A_SHIFT'(((64'(b) << TURN_A_SHIFT) + 64'(TURN_DIV_N / 2)) / TURN_DIV_N);
    end
    return tab;
  endfunction

  localparam frac_tab_t FRAC_TAB = build_frac_tab();

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
    32'h00000000, 32'h00000000
  };

endpackage

`default_nettype wire

FILE: rtl/rotate_point_about_center.sv
// Point rotation about a center: top level, built on rpac_pkg and rpac_cordic_stage.
// One word enters per cycle; the two unrolled CORDIC chains and the gain multipliers
// are fully pipelined, so throughput is one word per cycle while the output is taken.
// A stalled output holds the whole pipeline. Reset clears only the valid bits.
`timescale 1ns / 1ps
`default_nettype none
`include "rotate_point_about_center_assert.svh"

module rotate_point_about_center #(
  parameter int unsigned CORDIC_STAGES = rpac_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic        [15:0] turn_angle_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] rotated_x_o,
  output logic signed [31:0] rotated_y_o,
  output logic               clipped_o
);
  import rpac_pkg::*;

  localparam int unsigned N     = CORDIC_STAGES;
  localparam int unsigned FIN_W = DATA_W - FRAC_BITS + 1;

  typedef struct packed {
    logic signed [31:0]    px;
    logic signed [31:0]    py;
    logic signed [31:0]    cx;
    logic signed [31:0]    cy;
    logic [15:0]           t;
    logic [TURN_A_W-1:0]   a;
    logic                  bypass;
    logic                  vert;
    logic                  dy_pos;
    logic [32:0]           abs_dy;
  } vside_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic               bypass;
    logic               snapped;
    logic               snap_even;
    data_t              snap_val;
  } rside_t;

  function automatic logic [32:0] finish_coord(data_t v, logic signed [31:0] c);
    data_t                   rv;
    logic signed [FIN_W-1:0] r;
    rv = v + ROUND_FRAC;
    r  = $signed({rv[DATA_W-1], rv[DATA_W-1:FRAC_BITS]}) +
         $signed({{(FIN_W-32){c[31]}}, c});
    if (r[FIN_W-1:31] == '0 || r[FIN_W-1:31] == '1) begin
      return {1'b0, r[31:0]};
    end
    return r[FIN_W-1] ? {1'b1, S32_MIN} : {1'b1, S32_MAX};
  endfunction

  logic adv;
  logic out_valid_q;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  // input register
  logic               s0_valid_q;
  logic signed [32:0] s0_dx_q, s0_dy_q;
  logic signed [31:0] s0_px_q, s0_py_q, s0_cx_q, s0_cy_q;
  logic [15:0]        s0_t_q, t_mod_d;

  assign t_mod_d = (turn_angle_i >= FULL_TURN) ? (turn_angle_i - FULL_TURN) : turn_angle_i;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_dx_q <= 33'(point_x_i) - 33'(center_x_i);
      s0_dy_q <= 33'(point_y_i) - 33'(center_y_i);
      s0_px_q <= point_x_i;
      s0_py_q <= point_y_i;
      s0_cx_q <= center_x_i;
      s0_cy_q <= center_y_i;
      s0_t_q  <= t_mod_d;
    end
  end

  // vectoring chain
  logic         v_valid_q [N+1];
  vside_t       v_side_q  [N+1];
  cordic_word_t v_word_q  [N+1];

  data_t        dx_fx, dy_fx;
  cordic_word_t v0_d;
  vside_t       vs0_d;
  logic [33:0]  a_prod;

  always_comb begin
    dx_fx  = {{(DATA_W-33-FRAC_BITS){s0_dx_q[32]}}, s0_dx_q, {FRAC_BITS{1'b0}}};
    dy_fx  = {{(DATA_W-33-FRAC_BITS){s0_dy_q[32]}}, s0_dy_q, {FRAC_BITS{1'b0}}};
    a_prod = s0_t_q * TURN_RECIP;
    if (s0_dx_q[32]) begin
      v0_d.x = -dx_fx;
      v0_d.y = -dy_fx;
      v0_d.z = HALF_Z;
    end else begin
      v0_d.x = dx_fx;
      v0_d.y = dy_fx;
      v0_d.z = '0;
    end
    vs0_d.px     = s0_px_q;
    vs0_d.py     = s0_py_q;
    vs0_d.cx     = s0_cx_q;
    vs0_d.cy     = s0_cy_q;
    vs0_d.t      = s0_t_q;
    vs0_d.a      = a_prod[RECIP_SHIFT +: TURN_A_W];
    vs0_d.bypass = (s0_t_q == '0);
    vs0_d.vert   = (s0_dx_q == '0);
    vs0_d.dy_pos = !s0_dy_q[32] && (s0_dy_q != '0);
    vs0_d.abs_dy = s0_dy_q[32] ? 33'(-s0_dy_q) : 33'(s0_dy_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      v_word_q[0] <= v0_d;
      v_side_q[0] <= vs0_d;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_vec
    rpac_cordic_stage #(
      .SHIFT     (i),
      .VECTORING (1'b1)
    ) u_stage (
      .clk_i  (clk_i),
      .en_i   (adv),
      .word_i (v_word_q[i]),
      .word_o (v_word_q[i+1])
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_valid_q[i+1] <= 1'b0;
      end else if (adv) begin
        v_valid_q[i+1] <= v_valid_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        v_side_q[i+1] <= v_side_q[i];
      end
    end
  end

  // gain, turn and snap stages
  logic                g1_valid_q, g2_valid_q, g3_valid_q, g4_valid_q;
  vside_t              g1_side_q, g2_side_q, g3_side_q;
  logic [31:0]         g1_ang_q, g2_angb_q, g2_turn_q, g3_ang_q;
  logic [DATA_W-1:0]   g1_phi_d, g1_phi_q, g3_mhi_d, g3_mhi_q;
  logic [63:0]         g1_plo_d, g1_plo_q, g3_mlo_d, g3_mlo_q;
  logic [15:0]         a90_d;
  logic [TURN_B_W-1:0] g1_b_q;
  logic [64:0]         plo_r, mlo_r;
  data_t               g2_len_d, g2_len_q, g3_len_q, g4_xg_d, g4_xg_q;
  logic [31:0]         g2_angb_d, g2_turn_d;
  rside_t              g4_side_d, g4_side_q;
  ang_t                ths, g4_th_d, g4_th_q;
  logic                g4_neg_d, g4_neg_q;
  logic [31:0]         snap_d [4];
  logic [3:0]          snap_hit;
  logic [1:0]          snap_k;

  always_comb begin
    g1_phi_d = v_word_q[N].x[DATA_W-1:32] * GAIN_INV;
    g1_plo_d = v_word_q[N].x[31:0] * GAIN_INV;
    a90_d    = {{(16-TURN_A_W){1'b0}}, v_side_q[N].a} * TURN_DIV;

    plo_r = {1'b0, g1_plo_q} + {1'b0, ROUND_Q32};
    if (g1_side_q.vert) begin
      g2_len_d  = data_t'({g1_side_q.abs_dy, {FRAC_BITS{1'b0}}});
      g2_angb_d = g1_side_q.dy_pos ? QUARTER : THREE_QUARTER;
    end else begin
      g2_len_d  = g1_phi_q + DATA_W'(plo_r[64:32]);
      g2_angb_d = g1_ang_q;
    end
    g2_turn_d = {g1_side_q.a, {TURN_A_SHIFT{1'b0}}} + 32'(FRAC_TAB[g1_b_q]);

    g3_mhi_d = g2_len_q[DATA_W-1:32] * GAIN_INV;
    g3_mlo_d = g2_len_q[31:0] * GAIN_INV;

    mlo_r   = {1'b0, g3_mlo_q} + {1'b0, ROUND_Q32};
    g4_xg_d = g3_mhi_q + DATA_W'(mlo_r[64:32]);

    for (int k = 0; k < 4; k++) begin
      snap_d[k] = g3_ang_q - {2'(k), 30'b0};
      if (snap_d[k] > HALF) begin
        snap_d[k] = 32'd0 - snap_d[k];
      end
      snap_hit[k] = (snap_d[k] <= SNAP_TOL);
    end
    snap_k = snap_hit[0] ? 2'd0 : snap_hit[1] ? 2'd1 : snap_hit[2] ? 2'd2 : 2'd3;

    g4_side_d.px        = g3_side_q.px;
    g4_side_d.py        = g3_side_q.py;
    g4_side_d.cx        = g3_side_q.cx;
    g4_side_d.cy        = g3_side_q.cy;
    g4_side_d.bypass    = g3_side_q.bypass;
    g4_side_d.snapped   = |snap_hit;
    g4_side_d.snap_even = !snap_k[0];
    g4_side_d.snap_val  = snap_k[1] ? -g3_len_q : g3_len_q;

    ths = {{(ANG_W-32){g3_ang_q[31]}}, g3_ang_q};
    if (ths > QUARTER_Z) begin
      g4_neg_d = 1'b1;
      g4_th_d  = ths - HALF_Z;
    end else if (ths < -QUARTER_Z) begin
      g4_neg_d = 1'b1;
      g4_th_d  = ths + HALF_Z;
    end else begin
      g4_neg_d = 1'b0;
      g4_th_d  = ths;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      g1_side_q <= v_side_q[N];
      g1_ang_q  <= v_word_q[N].z[31:0];
      g1_phi_q  <= g1_phi_d;
      g1_plo_q  <= g1_plo_d;
      g1_b_q    <= TURN_B_W'(v_side_q[N].t - a90_d);
      g2_side_q <= g1_side_q;
      g2_len_q  <= g2_len_d;
      g2_angb_q <= g2_angb_d;
      g2_turn_q <= g2_turn_d;
      g3_side_q <= g2_side_q;
      g3_len_q  <= g2_len_q;
      g3_ang_q  <= g2_angb_q + g2_turn_q;
      g3_mhi_q  <= g3_mhi_d;
      g3_mlo_q  <= g3_mlo_d;
      g4_side_q <= g4_side_d;
      g4_xg_q   <= g4_xg_d;
      g4_th_q   <= g4_th_d;
      g4_neg_q  <= g4_neg_d;
    end
  end

  // rotation chain
  logic         r_valid_q [N+1];
  rside_t       r_side_q  [N+1];
  cordic_word_t r_word_q  [N+1];
  cordic_word_t r0_d;

  always_comb begin
    r0_d.x = g4_neg_q ? -g4_xg_q : g4_xg_q;
    r0_d.y = '0;
    r0_d.z = g4_th_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_word_q[0] <= r0_d;
      r_side_q[0] <= g4_side_q;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    rpac_cordic_stage #(
      .SHIFT     (i),
      .VECTORING (1'b0)
    ) u_stage (
      .clk_i  (clk_i),
      .en_i   (adv),
      .word_i (r_word_q[i]),
      .word_o (r_word_q[i+1])
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        r_valid_q[i+1] <= 1'b0;
      end else if (adv) begin
        r_valid_q[i+1] <= r_valid_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        r_side_q[i+1] <= r_side_q[i];
      end
    end
  end

  // valid bits outside the chains
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q   <= 1'b0;
      v_valid_q[0] <= 1'b0;
      g1_valid_q   <= 1'b0;
      g2_valid_q   <= 1'b0;
      g3_valid_q   <= 1'b0;
      g4_valid_q   <= 1'b0;
      r_valid_q[0] <= 1'b0;
      out_valid_q  <= 1'b0;
    end else if (adv) begin
      s0_valid_q   <= in_valid_i;
      v_valid_q[0] <= s0_valid_q;
      g1_valid_q   <= v_valid_q[N];
      g2_valid_q   <= g1_valid_q;
      g3_valid_q   <= g2_valid_q;
      g4_valid_q   <= g3_valid_q;
      r_valid_q[0] <= g4_valid_q;
      out_valid_q  <= r_valid_q[N];
    end
  end

  // round, move back by the center, saturate
  data_t              fin_vx, fin_vy;
  logic [32:0]        fin_x, fin_y;
  logic signed [31:0] rotated_x_q, rotated_y_q;
  logic               clipped_q;

  always_comb begin
    if (r_side_q[N].snapped) begin
      fin_vx = r_side_q[N].snap_even ? r_side_q[N].snap_val : '0;
      fin_vy = r_side_q[N].snap_even ? '0 : r_side_q[N].snap_val;
    end else begin
      fin_vx = r_word_q[N].x;
      fin_vy = r_word_q[N].y;
    end
    fin_x = finish_coord(fin_vx, r_side_q[N].cx);
    fin_y = finish_coord(fin_vy, r_side_q[N].cy);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (r_side_q[N].bypass) begin
        rotated_x_q <= r_side_q[N].px;
        rotated_y_q <= r_side_q[N].py;
        clipped_q   <= 1'b0;
      end else begin
        rotated_x_q <= fin_x[31:0];
        rotated_y_q <= fin_y[31:0];
        clipped_q   <= fin_x[32] | fin_y[32];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign rotated_x_o = rotated_x_q;
  assign rotated_y_o = rotated_y_q;
  assign clipped_o   = clipped_q;

  `RPAC_ASSERT_NOW(a_clip_sat, clk_i, rst_ni, out_valid_q && clipped_q,
    rotated_x_q == S32_MAX || rotated_x_q == S32_MIN ||
    rotated_y_q == S32_MAX || rotated_y_q == S32_MIN)
  `RPAC_ASSERT_NOW(a_turn_rem, clk_i, rst_ni, g1_valid_q,
    {{(16-TURN_B_W){1'b0}}, g1_b_q} < TURN_DIV)
  `RPAC_ASSERT_NOW(a_vec_pos, clk_i, rst_ni, v_valid_q[N] && !v_side_q[N].vert,
    !v_word_q[N].x[DATA_W-1])
  `RPAC_ASSERT_NEXT(a_hold, clk_i, rst_ni, !adv && v_valid_q[N], v_valid_q[N])

endmodule

`default_nettype wire

FILE: rtl/rpac_cordic_stage.sv
// One registered CORDIC micro-rotation, vectoring or rotation mode.
// Depends on rpac_pkg for the word type and the arctangent table.
`timescale 1ns / 1ps
`default_nettype none

module rpac_cordic_stage #(
  parameter int unsigned SHIFT     = 0,
  parameter bit          VECTORING = 1'b1
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  rpac_pkg::cordic_word_t word_i,
  output rpac_pkg::cordic_word_t word_o
);
  import rpac_pkg::*;

  localparam ang_t ATAN_Z = {{(ANG_W-32){1'b0}}, ATAN_TAB[SHIFT]};

  data_t        xi, yi, xs, ys;
  ang_t         zi;
  logic         up;
  cordic_word_t word_d, word_q;

  always_comb begin
    xi = word_i.x;
    yi = word_i.y;
    zi = word_i.z;
    xs = xi >>> SHIFT;
    ys = yi >>> SHIFT;
    up = VECTORING ? yi[DATA_W-1] : !zi[ANG_W-1];
    if (up) begin
      word_d.x = xi - ys;
      word_d.y = yi + xs;
      word_d.z = zi - ATAN_Z;
    end else begin
      word_d.x = xi + ys;
      word_d.y = yi - xs;
      word_d.z = zi + ATAN_Z;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign word_o = word_q;

endmodule

`default_nettype wire
